// ----- src/grey_world_white_balance_macros.svh -----
`ifndef GREY_WORLD_WHITE_BALANCE_MACROS_SVH
`define GREY_WORLD_WHITE_BALANCE_MACROS_SVH

// Same-cycle implication, checked on every rising edge once reset is released.
`define GWWB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grey world white balance check failed");

// Next-cycle implication, checked on every rising edge once reset is released.
`define GWWB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grey world white balance check failed");

`endif

// ----- src/gwwb_pkg.sv -----
package gwwb_pkg;

  // Frame store size and gain precision.
  localparam int MAX_PIXELS     = 16384;
  localparam int GAIN_FRAC_BITS = 16;

  // Derived widths.
  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = $clog2(255 * MAX_PIXELS + 1);
  localparam int TOT_W  = $clog2(3 * 255 * MAX_PIXELS + 1);
  localparam int NUM_W  = TOT_W + GAIN_FRAC_BITS;
  localparam int GAIN_W = 9 + GAIN_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int PIX_W  = 24;
  localparam int CHAN_W = 2;

  // Gain saturation point, 256.0.
  localparam logic [GAIN_W-1:0] GAIN_LIMIT = {1'b1, {(GAIN_W-1){1'b0}}};

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Channel indexes.
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_end;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       final_pixel;
    logic       status;
  } pixel_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GAIN_START,
    ST_GAIN_WAIT
  } gwwb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_pix;
    logic              out_load;
    logic              div_start;
    logic              gain_store;
    logic              frame_done;
    logic [CHAN_W-1:0] chan;
  } gwwb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } gwwb_sts_t;

endpackage

// ----- src/gwwb_ram.sv -----
module gwwb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/gwwb_div.sv -----
module gwwb_div import gwwb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TOT_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOT_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [TOT_W-1:0]     den_r, den_nxt;
  logic [TOT_W:0]       rem_shift;
  logic [TOT_W:0]       rem_diff;
  logic                 fits;

  // One restoring step: shift in the next numerator bit and try a subtract.
  assign rem_shift = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign fits      = rem_shift >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[TOT_W-1:0] : rem_shift[TOT_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- src/gwwb_ctrl.sv -----
module gwwb_ctrl import gwwb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  pixel_in_t in_data,
  output logic      in_stall,
  input  gwwb_sts_t sts,
  output gwwb_cmd_t cmd
);

  gwwb_state_t       state_r, state_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic              accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // Next state and channel index.
  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_FETCH) begin
            state_nxt = ST_FETCH;
          end else if (in_data.frame_end) begin
            state_nxt = ST_GAIN_START;
            chan_nxt  = CH_RED;
          end
        end
      end
      ST_FETCH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GAIN_START: begin
        state_nxt = ST_GAIN_WAIT;
      end
      ST_GAIN_WAIT: begin
        if (sts.div_done) begin
          if (chan_r == CH_BLUE) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_GAIN_START;
            chan_nxt  = chan_r + CHAN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd            = '0;
    cmd.chan       = chan_r;
    in_stall       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_pix = accept && (in_data.cmd == CMD_LOAD);
      end
      ST_FETCH: begin
        cmd.out_load = sts.out_free;
      end
      ST_GAIN_START: begin
        cmd.div_start = 1'b1;
      end
      ST_GAIN_WAIT: begin
        cmd.gain_store = sts.div_done;
        cmd.frame_done = sts.div_done && (chan_r == CH_BLUE);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= CH_RED;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

// ----- src/gwwb_dp.sv -----
module gwwb_dp import gwwb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pixel_in_t  in_data,
  input  gwwb_cmd_t  cmd,
  output gwwb_sts_t  sts,
  output logic       out_valid,
  input  logic       out_stall,
  output pixel_out_t out_data
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rp_r, rp_nxt;
  logic [SUM_W-1:0]  red_sum_r, red_sum_nxt;
  logic [SUM_W-1:0]  green_sum_r, green_sum_nxt;
  logic [SUM_W-1:0]  blue_sum_r, blue_sum_nxt;
  logic [GAIN_W-1:0] gain_r [3];
  logic [GAIN_W-1:0] gain_nxt [3];
  logic              ready_r, ready_nxt;
  logic              out_valid_r, out_valid_nxt;
  pixel_out_t        out_data_r, out_data_nxt;

  logic [CNT_W-1:0]  base_count;
  logic [SUM_W-1:0]  base_red, base_green, base_blue;
  logic              room;
  logic              ram_we;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic [SUM_W-1:0]  chan_sum;
  logic [TOT_W-1:0]  total, chan_ext, den;
  logic [NUM_W-1:0]  num, quo;
  logic              div_done;
  logic [GAIN_W-1:0] gain_val;
  logic              fetch_ok;
  logic [CNT_W-1:0]  rp_inc;

  // Scale one component by its gain, truncate and clamp to 255.
  function automatic logic [7:0] scale_comp(logic [7:0] c, logic [GAIN_W-1:0] g);
    logic [GAIN_W+7:0] prod;
    logic [GAIN_W+7:0] shifted;
    prod    = (GAIN_W+8)'(c) * (GAIN_W+8)'(g);
    shifted = prod >> GAIN_FRAC_BITS;
    if (|shifted[GAIN_W+7:8]) begin
      return 8'd255;
    end
    return shifted[7:0];
  endfunction

  // A load after a finished frame starts from a cleared frame.
  assign base_count = ready_r ? '0 : count_r;
  assign base_red   = ready_r ? '0 : red_sum_r;
  assign base_green = ready_r ? '0 : green_sum_r;
  assign base_blue  = ready_r ? '0 : blue_sum_r;
  assign room       = base_count < CNT_W'(MAX_PIXELS);
  assign ram_we     = cmd.load_pix && room;
  assign ram_wdata  = {in_data.red_in, in_data.green_in, in_data.blue_in};

  // Frame store; the read port always follows the read pointer.
  gwwb_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(base_count[ADDR_W-1:0]),
    .wdata(ram_wdata),
    .raddr(rp_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // Divider operands for the channel being worked on.
  always_comb begin
    case (cmd.chan)
      CH_RED:   chan_sum = red_sum_r;
      CH_GREEN: chan_sum = green_sum_r;
      default:  chan_sum = blue_sum_r;
    endcase
  end

  assign total    = TOT_W'(red_sum_r) + TOT_W'(green_sum_r) + TOT_W'(blue_sum_r);
  assign chan_ext = TOT_W'(chan_sum);
  assign den      = chan_ext + (chan_ext << 1);
  assign num      = {total, {GAIN_FRAC_BITS{1'b0}}};

  gwwb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .done (div_done)
  );

  // Zero channel sum gives gain zero; otherwise saturate at 256.0.
  always_comb begin
    if (chan_sum == '0) begin
      gain_val = '0;
    end else if (quo > NUM_W'(GAIN_LIMIT)) begin
      gain_val = GAIN_LIMIT;
    end else begin
      gain_val = quo[GAIN_W-1:0];
    end
  end

  assign fetch_ok = ready_r && (rp_r < count_r);
  assign rp_inc   = rp_r + CNT_W'(1);

  // Frame state, gains and output register.
  always_comb begin
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    gain_nxt      = gain_r;
    ready_nxt     = ready_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.load_pix) begin
      if (ready_r) begin
        gain_nxt[0] = '0;
        gain_nxt[1] = '0;
        gain_nxt[2] = '0;
        rp_nxt      = '0;
        ready_nxt   = 1'b0;
      end
      count_nxt     = base_count;
      red_sum_nxt   = base_red;
      green_sum_nxt = base_green;
      blue_sum_nxt  = base_blue;
      if (room) begin
        count_nxt     = base_count + CNT_W'(1);
        red_sum_nxt   = base_red + SUM_W'(in_data.red_in);
        green_sum_nxt = base_green + SUM_W'(in_data.green_in);
        blue_sum_nxt  = base_blue + SUM_W'(in_data.blue_in);
      end
    end

    if (cmd.gain_store) begin
      gain_nxt[cmd.chan] = gain_val;
    end

    if (cmd.frame_done) begin
      ready_nxt = 1'b1;
      rp_nxt    = '0;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      if (fetch_ok) begin
        out_data_nxt.red_out     = scale_comp(ram_rdata[23:16], gain_r[CH_RED]);
        out_data_nxt.green_out   = scale_comp(ram_rdata[15:8], gain_r[CH_GREEN]);
        out_data_nxt.blue_out    = scale_comp(ram_rdata[7:0], gain_r[CH_BLUE]);
        out_data_nxt.final_pixel = (rp_inc == count_r);
        out_data_nxt.status      = STATUS_OK;
        rp_nxt                   = rp_inc;
      end else begin
        out_data_nxt        = '0;
        out_data_nxt.status = STATUS_EMPTY;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rp_r        <= '0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      gain_r[0]   <= '0;
      gain_r[1]   <= '0;
      gain_r[2]   <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      gain_r      <= gain_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// ----- src/grey_world_white_balance.sv -----
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  pixel_in_t: cmd, pixel, frame_end
// out_      output     out_valid / out_stall pixel_out_t: pixel, final_pixel, status
//
// A load word is taken in the idle state; a fetch word then holds off the input (frame store read, then output).
// The load that closes a frame then runs the shared serial divider,
// which forms the three gains one bit per cycle.
// Synchronous active-low reset clears counts, sums, gains and the ready flag.
// Loads are taken while a result waits in the output register; a fetch waits for it.
module grey_world_white_balance import gwwb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pixel_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pixel_out_t out_data
);

`include "grey_world_white_balance_macros.svh"

  gwwb_cmd_t  ctrl_cmd;
  gwwb_sts_t  dp_sts;
  logic [3:0] dp_ops;

  // Sequencer for loads, fetches and the gain computation.
  gwwb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .in_stall(in_stall),
    .sts     (dp_sts),
    .cmd     (ctrl_cmd)
  );

  // Frame store, sums, divider, gains and output register.
  gwwb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (ctrl_cmd),
    .sts      (dp_sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Datapath operations requested in this cycle.
  assign dp_ops = {ctrl_cmd.load_pix, ctrl_cmd.out_load, ctrl_cmd.div_start,
                   ctrl_cmd.gain_store};

  // The output register is never overwritten while a word waits in it.
  `GWWB_ASSERT_IMP(a_out_no_overwrite, ctrl_cmd.out_load, dp_sts.out_free)
  // A gain is only stored once the divider has finished.
  `GWWB_ASSERT_IMP(a_gain_after_div, ctrl_cmd.gain_store, dp_sts.div_done)
  // At most one datapath operation per cycle.
  `GWWB_ASSERT_IMP(a_one_op, 1'b1, $onehot0(dp_ops))
  // An accepted fetch holds off the input while the store is read.
  `GWWB_ASSERT_NXT(a_fetch_stalls, in_valid && !in_stall && (in_data.cmd == CMD_FETCH), in_stall)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gwwb_pkg::*;

  localparam int RANDOM_WORDS   = 1250;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IN_W           = $bits(pixel_in_t);

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  pixel_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pixel_out_t out_data;

  grey_world_white_balance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shared state between the test tasks, the sender and the result checker.
  pixel_out_t expected_pixels[$];
  int         mismatch_count = 0;
  int         words_accepted = 0;
  bit         quiet_sender   = 1'b0;
  bit         quiet_receiver = 1'b0;
  int         hold_requests  = 0;

  // Predicted block state: the stored frame, its sums, gains and read position.
  logic [PIX_W-1:0]  frame_pixels [0:MAX_PIXELS-1];
  logic [CNT_W-1:0]  loaded_count = '0;
  logic [SUM_W-1:0]  sum_red      = '0;
  logic [SUM_W-1:0]  sum_green    = '0;
  logic [SUM_W-1:0]  sum_blue     = '0;
  logic [GAIN_W-1:0] gain_red     = '0;
  logic [GAIN_W-1:0] gain_green   = '0;
  logic [GAIN_W-1:0] gain_blue    = '0;
  logic [CNT_W-1:0]  fetch_index  = '0;
  bit                frame_closed = 1'b0;

  // Gain is total / (3 * channel sum) in fixed point, truncated and saturated at 256.0.
  function automatic logic [GAIN_W-1:0] channel_gain(input logic [TOT_W-1:0] total,
                                                     input logic [SUM_W-1:0] chan_sum);
    logic [63:0] quot;
    if (chan_sum == '0) begin
      return '0;
    end
    quot = (64'(total) << GAIN_FRAC_BITS) / (64'(chan_sum) * 64'd3);
    if (quot > 64'(GAIN_LIMIT)) begin
      quot = 64'(GAIN_LIMIT);
    end
    return quot[GAIN_W-1:0];
  endfunction

  function automatic logic [7:0] apply_gain(input logic [7:0] comp,
                                            input logic [GAIN_W-1:0] gain);
    logic [63:0] prod;
    prod = (64'(comp) * 64'(gain)) >> GAIN_FRAC_BITS;
    return (prod > 64'd255) ? 8'd255 : prod[7:0];
  endfunction

  // Advance the predicted state by one accepted word and queue any result it causes.
  task automatic predict_balance(input pixel_in_t w);
    pixel_out_t       res;
    logic [TOT_W-1:0] total;
    logic [PIX_W-1:0] px;
    if (w.cmd == CMD_LOAD) begin
      if (frame_closed) begin
        loaded_count = '0;
        sum_red      = '0;
        sum_green    = '0;
        sum_blue     = '0;
        gain_red     = '0;
        gain_green   = '0;
        gain_blue    = '0;
        fetch_index  = '0;
        frame_closed = 1'b0;
      end
      // A full store drops the pixel, but its end mark still counts.
      if (loaded_count < CNT_W'(MAX_PIXELS)) begin
        frame_pixels[loaded_count[ADDR_W-1:0]] = {w.red_in, w.green_in, w.blue_in};
        loaded_count = loaded_count + CNT_W'(1);
        sum_red      = sum_red + SUM_W'(w.red_in);
        sum_green    = sum_green + SUM_W'(w.green_in);
        sum_blue     = sum_blue + SUM_W'(w.blue_in);
      end
      if (w.frame_end) begin
        total        = TOT_W'(sum_red) + TOT_W'(sum_green) + TOT_W'(sum_blue);
        gain_red     = channel_gain(total, sum_red);
        gain_green   = channel_gain(total, sum_green);
        gain_blue    = channel_gain(total, sum_blue);
        fetch_index  = '0;
        frame_closed = 1'b1;
      end
    end else begin
      res = '0;
      if (!frame_closed || fetch_index >= loaded_count) begin
        res.status = STATUS_EMPTY;
      end else begin
        px              = frame_pixels[fetch_index[ADDR_W-1:0]];
        res.red_out     = apply_gain(px[23:16], gain_red);
        res.green_out   = apply_gain(px[15:8], gain_green);
        res.blue_out    = apply_gain(px[7:0], gain_blue);
        res.final_pixel = (fetch_index + CNT_W'(1) == loaded_count);
        res.status      = STATUS_OK;
        fetch_index     = fetch_index + CNT_W'(1);
      end
      expected_pixels.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // Drive one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input pixel_in_t w);
    int gap;
    gap = (!quiet_sender && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_accepted++;
    predict_balance(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic load_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fe);
    pixel_in_t w;
    w.cmd       = CMD_LOAD;
    w.red_in    = r;
    w.green_in  = g;
    w.blue_in   = b;
    w.frame_end = fe;
    send_word(w);
  endtask

  // Fetch words carry random pixel bits, which the block ignores.
  task automatic fetch_pixel();
    pixel_in_t w;
    w     = pixel_in_t'(IN_W'($urandom));
    w.cmd = CMD_FETCH;
    send_word(w);
  endtask

  // Random pixel shaped by the frame kind: any color, one channel absent,
  // one channel nearly absent (drives gain saturation), or close to a grey level.
  function automatic pixel_in_t make_load(input int kind, input int chan, input int base,
                                          input logic fe);
    logic [7:0] c [3];
    pixel_in_t  w;
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0: c[k] = 8'($urandom);
        1: c[k] = (k == chan) ? 8'd0 : 8'($urandom);
        2: c[k] = (k == chan) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(128, 255));
        default: begin
          c[k] = 8'($urandom_range((base < 8) ? 0 : base - 8, (base > 247) ? 255 : base + 8));
        end
      endcase
    end
    w.cmd       = CMD_LOAD;
    w.red_in    = c[0];
    w.green_in  = c[1];
    w.blue_in   = c[2];
    w.frame_end = fe;
    return w;
  endfunction

  function automatic int pick_frame_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      return $urandom_range(1, 12);
    end else if (r < 19) begin
      return $urandom_range(13, 64);
    end
    return $urandom_range(65, 300);
  endfunction

  // Hand-picked frames: empty fetches, saturation, zero sums, clamping, restarts.
  task automatic test_directed();
    fetch_pixel();                          // nothing loaded yet
    load_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    load_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    load_pixel(8'd0, 8'd0, 8'd1, 1'b1);     // blue gain saturates
    repeat (4) fetch_pixel();               // last one runs past the end
    load_pixel(8'd0, 8'd0, 8'd0, 1'b1);     // every sum zero
    repeat (2) fetch_pixel();
    load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    load_pixel(8'd0, 8'd0, 8'd255, 1'b1);   // red and green clamp at 255
    fetch_pixel();                          // read only part of the frame
    load_pixel(8'd128, 8'd64, 8'd32, 1'b1);
    repeat (2) fetch_pixel();
    load_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    fetch_pixel();                          // frame still open
    load_pixel(8'd8, 8'd0, 8'd9, 1'b1);     // closes the open frame
    repeat (2) fetch_pixel();
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while fetches keep coming.
  task automatic test_output_backpressure();
    int i;
    quiet_sender = 1'b1;
    for (i = 0; i < 8; i++) begin
      send_word(make_load(0, 0, 0, i == 7));
    end
    hold_requests++;
    repeat (24) fetch_pixel();
    wait_drained();
    quiet_sender = 1'b0;
  endtask

  // Mostly whole frames followed by their fetches, with stray fetches,
  // partial reads and frames left open so they run into the next one.
  task automatic test_random_frames();
    int start, size, fetches, kind, chan, base, i;
    bit close_frame;
    start = words_accepted;
    while (words_accepted - start < RANDOM_WORDS) begin
      quiet_sender   = ($urandom_range(0, 4) == 0);
      quiet_receiver = ($urandom_range(0, 4) == 0);
      size           = pick_frame_size();
      kind           = $urandom_range(0, 3);
      chan           = $urandom_range(0, 2);
      base           = $urandom_range(0, 255);
      close_frame    = ($urandom_range(0, 9) != 0);
      for (i = 0; i < size; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          fetch_pixel();
        end
        send_word(make_load(kind, chan, base, close_frame && i == size - 1));
      end
      fetches = ($urandom_range(0, 4) == 0) ? $urandom_range(0, size)
                                            : size + $urandom_range(0, 2);
      repeat (fetches) fetch_pixel();
    end
    wait_drained();
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // Receiver: a requested long hold first, otherwise random runs of stall and ready.
  int hold_seen = 0;
  int hold_left = 0;
  int run_left  = 0;
  bit stalling  = 1'b0;

  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_receiver) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stalling = ($urandom_range(0, 3) == 0);
        run_left = stalling ? gap_length() : $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= stalling;
    end
  end

  // Compare every accepted result with the oldest expectation.
  pixel_out_t want_pixel;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no fetch waiting");
      end else begin
        want_pixel = expected_pixels.pop_front();
        check_field("red_out", out_data.red_out, want_pixel.red_out);
        check_field("green_out", out_data.green_out, want_pixel.green_out);
        check_field("blue_out", out_data.blue_out, want_pixel.blue_out);
        check_field("final_pixel", 8'(out_data.final_pixel), 8'(want_pixel.final_pixel));
        check_field("status", 8'(out_data.status), 8'(want_pixel.status));
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_backpressure();
    test_random_frames();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d fetch results never arrived", expected_pixels.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- grey_world_white_balance.f -----
+incdir+src
src/gwwb_pkg.sv
src/gwwb_ram.sv
src/gwwb_div.sv
src/gwwb_ctrl.sv
src/gwwb_dp.sv
src/grey_world_white_balance.sv
tb/sv/tb_top.sv
